@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the timer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cond is never true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/core/hmsct_pkg.sv @@
// Types and constants of the countdown timer.
package hmsct_pkg;

  localparam int unsigned TotalW = 19;
  localparam int unsigned HoursW = 7;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;
  localparam int unsigned TenthW = 4;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned SpinW  = 2;

  localparam logic [ModeW-1:0] MODE_IDLE = 2'd0;
  localparam logic [ModeW-1:0] MODE_RUN  = 2'd1;
  localparam logic [ModeW-1:0] MODE_STOP = 2'd2;

  localparam logic [TotalW-1:0] MAX_START   = 19'd359999;
  localparam logic [TotalW-1:0] RST_TOTAL   = 19'd3692;
  localparam logic [HoursW-1:0] RST_HOURS   = 7'd1;
  localparam logic [MinW-1:0]   RST_MINUTES = 6'd1;
  localparam logic [SecW-1:0]   RST_SECONDS = 6'd32;

  localparam logic [MinW-1:0]   LAST_MINUTE = 6'd59;
  localparam logic [SecW-1:0]   LAST_SECOND = 6'd59;
  localparam logic [TenthW-1:0] LAST_TENTH  = 4'd9;

  // Reciprocals for the hour and minute split: ceil(2^31/3600), ceil(2^17/60).
  localparam logic [19:0] HOUR_RECIP = 20'd596524;
  localparam int unsigned HourShift  = 31;
  localparam logic [11:0] MIN_RECIP  = 12'd2185;
  localparam int unsigned MinShift   = 17;
  localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
  localparam logic [11:0] SEC_PER_MIN  = 12'd60;

  typedef struct packed {
    logic [TotalW-1:0] total;
    logic [HoursW-1:0] hours;
    logic [MinW-1:0]   minutes;
    logic [SecW-1:0]   seconds;
  } load_time_t;

endpackage

@@ rtl/core/hmsct_split.sv @@
// Start value register with its hours/minutes/seconds split pipeline.
module hmsct_split (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [hmsct_pkg::TotalW-1:0]        cfg_data_i,
  output logic                                cfg_ready_o,
  output logic                                busy_o,
  output hmsct_pkg::load_time_t               load_o
);

  logic [3:0]                        stg_q, stg_d;
  logic [hmsct_pkg::TotalW-1:0]      val_q, val_d;
  logic [hmsct_pkg::HoursW-1:0]      hr_q, hr_d;
  logic [11:0]                       rem_q, rem_d;
  logic [hmsct_pkg::MinW-1:0]        min_q, min_d;
  hmsct_pkg::load_time_t             load_q, load_d;
  logic                              cfg_acc;
  logic [38:0]                       hr_prod;
  logic [hmsct_pkg::TotalW-1:0]      rem_full;
  logic [23:0]                       min_prod;
  logic [11:0]                       sec_full;

  assign cfg_ready_o = ~busy_o;
  assign busy_o      = |stg_q;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;
  assign load_o      = load_q;

  always_comb begin
    stg_d = {stg_q[2:0], cfg_acc};
    val_d = val_q;
    if (cfg_acc) begin
      val_d = (cfg_data_i > hmsct_pkg::MAX_START) ? hmsct_pkg::MAX_START : cfg_data_i;
    end
    hr_prod  = 39'(val_q) * 39'(hmsct_pkg::HOUR_RECIP);
    hr_d     = hr_prod[hmsct_pkg::HourShift +: hmsct_pkg::HoursW];
    rem_full = val_q - 19'(hr_q) * 19'(hmsct_pkg::SEC_PER_HOUR);
    rem_d    = rem_full[11:0];
    min_prod = 24'(rem_q) * 24'(hmsct_pkg::MIN_RECIP);
    min_d    = min_prod[hmsct_pkg::MinShift +: hmsct_pkg::MinW];
    sec_full = rem_q - 12'(min_q) * hmsct_pkg::SEC_PER_MIN;
    load_d   = load_q;
    if (stg_q[3]) begin
      load_d.total   = val_q;
      load_d.hours   = hr_q;
      load_d.minutes = min_q;
      load_d.seconds = sec_full[hmsct_pkg::SecW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q          <= '0;
      load_q.total   <= hmsct_pkg::RST_TOTAL;
      load_q.hours   <= hmsct_pkg::RST_HOURS;
      load_q.minutes <= hmsct_pkg::RST_MINUTES;
      load_q.seconds <= hmsct_pkg::RST_SECONDS;
    end else begin
      stg_q  <= stg_d;
      load_q <= load_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    hr_q  <= hr_d;
    rem_q <= rem_d;
    min_q <= min_d;
  end

endmodule

@@ rtl/core/hms_countdown_timer_unit.sv @@
// Top level of the hours:minutes:seconds countdown timer.
// Usage:
//   Input stream s_axis: one beat per polling step, tdata[0] = tenth-second
//   tick, tdata[1] = start/stop button level. Output stream m_axis: one beat
//   per input beat with the timer state after that step.
//   Config channel cfg: start value in seconds, clamped to 359999. After a
//   write the value is split into h:m:s; the input channel and the config
//   channel are held off while the split runs.
// Output: each result beat appears in the cycle after its input beat is taken.
// Throughput: 1 beat per cycle unless m_axis stalls or a split runs; the
//   whole step is one pass of logic from the state registers back into
//   themselves, which double as the output register.
// Reset: idle, 1:01:32.0, spinner dash, start value 3692, no result pending.
// Stall: while a result waits on m_axis_tready, a new input beat is taken
//   only in the cycle that the waiting result is taken; otherwise
//   s_axis_tready stays low.
`include "assert_macros.svh"

module hms_countdown_timer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [18:0] cfg_data_i,
  output logic        cfg_ready_o,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // tick [0], button [1], zero [7:2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // run_state [1:0], hours_left [8:2],
                                      // minutes_left [14:9], seconds_left [20:15],
                                      // tenths_left [24:21], spinner [26:25], zero
);

  logic                              split_busy;
  hmsct_pkg::load_time_t             load_time;

  logic                              in_acc;
  logic                              m_valid_q, m_valid_d;
  logic [hmsct_pkg::ModeW-1:0]       mode_q, mode_d;
  logic [hmsct_pkg::TotalW-1:0]      total_q, total_d;
  logic [hmsct_pkg::HoursW-1:0]      hours_q, hours_d;
  logic [hmsct_pkg::MinW-1:0]        min_q, min_d;
  logic [hmsct_pkg::SecW-1:0]        sec_q, sec_d;
  logic [hmsct_pkg::TenthW-1:0]      tenth_q, tenth_d;
  logic [hmsct_pkg::SpinW-1:0]       spin_q, spin_d;
  logic                              btn_prev_q, btn_prev_d;
  logic                              tick, button, btn_rise, count_en;

  hmsct_split u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .busy_o      (split_busy),
    .load_o      (load_time)
  );

  assign tick          = s_axis_tdata[0];
  assign button        = s_axis_tdata[1];
  assign btn_rise      = button & ~btn_prev_q;
  assign s_axis_tready = ~split_busy & (~m_valid_q | m_axis_tready);
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'd0, spin_q, tenth_q, sec_q, min_q, hours_q, mode_q};

  always_comb begin
    mode_d     = mode_q;
    total_d    = total_q;
    hours_d    = hours_q;
    min_d      = min_q;
    sec_d      = sec_q;
    tenth_d    = tenth_q;
    spin_d     = spin_q;
    btn_prev_d = btn_prev_q;
    count_en   = 1'b0;
    m_valid_d  = m_valid_q;
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (in_acc) begin
      m_valid_d  = 1'b1;
      btn_prev_d = button;
      if (btn_rise) begin
        unique case (mode_q)
          hmsct_pkg::MODE_IDLE: mode_d = hmsct_pkg::MODE_RUN;
          hmsct_pkg::MODE_RUN:  mode_d = hmsct_pkg::MODE_STOP;
          default: begin
            mode_d  = hmsct_pkg::MODE_IDLE;
            total_d = load_time.total;
            hours_d = load_time.hours;
            min_d   = load_time.minutes;
            sec_d   = load_time.seconds;
            tenth_d = '0;
          end
        endcase
      end
      count_en = (mode_d == hmsct_pkg::MODE_RUN) & tick
               & ~((total_d == '0) & (tenth_d == '0));
      if (count_en) begin
        spin_d = spin_d + 2'd1;
        if (tenth_d != '0) begin
          tenth_d = tenth_d - 4'd1;
        end else begin
          tenth_d = hmsct_pkg::LAST_TENTH;
          total_d = total_d - 19'd1;
          if (sec_d != '0) begin
            sec_d = sec_d - 6'd1;
          end else begin
            sec_d = hmsct_pkg::LAST_SECOND;
            if (min_d != '0) begin
              min_d = min_d - 6'd1;
            end else begin
              min_d = hmsct_pkg::LAST_MINUTE;
              if (hours_d != '0) begin
                hours_d = hours_d - 7'd1;
              end
            end
          end
        end
      end
      if ((total_d == '0) && (tenth_d == '0)) begin
        mode_d = hmsct_pkg::MODE_STOP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q  <= 1'b0;
      mode_q     <= hmsct_pkg::MODE_IDLE;
      total_q    <= hmsct_pkg::RST_TOTAL;
      hours_q    <= hmsct_pkg::RST_HOURS;
      min_q      <= hmsct_pkg::RST_MINUTES;
      sec_q      <= hmsct_pkg::RST_SECONDS;
      tenth_q    <= '0;
      spin_q     <= '0;
      btn_prev_q <= 1'b0;
    end else begin
      m_valid_q  <= m_valid_d;
      mode_q     <= mode_d;
      total_q    <= total_d;
      hours_q    <= hours_d;
      min_q      <= min_d;
      sec_q      <= sec_d;
      tenth_q    <= tenth_d;
      spin_q     <= spin_d;
      btn_prev_q <= btn_prev_d;
    end
  end

  `ASSERT_CLK(a_cfg_blocks_input, clk_i, rst_ni,
    (cfg_valid_i && cfg_ready_o) |=> !s_axis_tready, "input taken during split")
  `ASSERT_NEVER(a_zero_not_stopped, clk_i, rst_ni,
    (total_q == '0) && (tenth_q == '0) && (mode_q != hmsct_pkg::MODE_STOP),
    "time at zero outside stopped")
  `ASSERT_CLK(a_no_count_off_run, clk_i, rst_ni,
    (in_acc && !btn_rise && (mode_q != hmsct_pkg::MODE_RUN)) |=>
      ($stable(total_q) && $stable(tenth_q)), "time moved while not running")
  `ASSERT_CLK(a_spin_on_beat, clk_i, rst_ni,
    !in_acc |=> $stable(spin_q), "spinner moved without input beat")

endmodule

@@ dv/hms_countdown_timer_unit_test.sv @@
// Self-checking testbench for the hours:minutes:seconds countdown timer unit.
module hms_countdown_timer_unit_test;
  import hmsct_pkg::*;

  typedef struct packed {
    logic [SpinW-1:0]  spinner;
    logic [TenthW-1:0] tenths;
    logic [SecW-1:0]   seconds;
    logic [MinW-1:0]   minutes;
    logic [HoursW-1:0] hours;
    logic [ModeW-1:0]  run_state;
  } timer_view_t;

  localparam int unsigned ViewW = $bits(timer_view_t);

  typedef struct packed {
    logic              is_cfg;
    logic [TotalW-1:0] cfg_value;
    logic              tick;
    logic              button;
    logic              typed;
    logic [ModeW-1:0]  run_state;
    logic [HoursW-1:0] hours;
    logic [MinW-1:0]   minutes;
    logic [SecW-1:0]   seconds;
    logic [TenthW-1:0] tenths;
    logic [SpinW-1:0]  spinner;
  } plan_row_t;

  localparam int PLAN_ROWS = 29;
  localparam int PLAN_STEPS = 25;
  localparam int RANDOM_STEPS = 950;
  localparam int QUIET_FROM = PLAN_STEPS + 800;
  localparam int LONG_HOLD = 120;
  localparam int STUCK_LIMIT = 1000;

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{1'b0, 19'd0, 1'b1, 1'b0, 1'b1, MODE_IDLE, 7'd1, 6'd1, 6'd32, 4'd0, 2'd0},
    '{1'b0, 19'd0, 1'b0, 1'b1, 1'b1, MODE_RUN,  7'd1, 6'd1, 6'd32, 4'd0, 2'd0},
    '{1'b0, 19'd0, 1'b1, 1'b1, 1'b1, MODE_RUN,  7'd1, 6'd1, 6'd31, 4'd9, 2'd1},
    '{1'b0, 19'd0, 1'b1, 1'b0, 1'b0, MODE_RUN,  7'd0, 6'd0, 6'd0,  4'd0, 2'd0},
    '{1'b0, 19'd0, 1'b0, 1'b1, 1'b1, MODE_STOP, 7'd1, 6'd1, 6'd31, 4'd8, 2'd2},
    '{1'b0, 19'd0, 1'b1, 1'b0, 1'b1, MODE_STOP, 7'd1, 6'd1, 6'd31, 4'd8, 2'd2},
    '{1'b1, 19'd0, 1'b0, 1'b0, 1'b0, MODE_IDLE, 7'd0, 6'd0, 6'd0,  4'd0, 2'd0},
    '{1'b0, 19'd0, 1'b0, 1'b1, 1'b1, MODE_STOP, 7'd0, 6'd0, 6'd0,  4'd0, 2'd2},
    '{1'b0, 19'd0, 1'b1, 1'b0, 1'b1, MODE_STOP, 7'd0, 6'd0, 6'd0,  4'd0, 2'd2},
    '{1'b0, 19'd0, 1'b1, 1'b1, 1'b1, MODE_STOP, 7'd0, 6'd0, 6'd0,  4'd0, 2'd2},
    '{1'b1, 19'd524287, 1'b0, 1'b0, 1'b0, MODE_IDLE, 7'd0, 6'd0, 6'd0, 4'd0, 2'd0},
    '{1'b0, 19'd0, 1'b0, 1'b0, 1'b1, MODE_STOP, 7'd0,  6'd0,  6'd0,  4'd0, 2'd2},
    '{1'b0, 19'd0, 1'b0, 1'b1, 1'b1, MODE_IDLE, 7'd99, 6'd59, 6'd59, 4'd0, 2'd2},
    '{1'b0, 19'd0, 1'b0, 1'b0, 1'b1, MODE_IDLE, 7'd99, 6'd59, 6'd59, 4'd0, 2'd2},
    '{1'b0, 19'd0, 1'b1, 1'b1, 1'b1, MODE_RUN,  7'd99, 6'd59, 6'd58, 4'd9, 2'd3},
    '{1'b0, 19'd0, 1'b1, 1'b0, 1'b0, MODE_RUN,  7'd0,  6'd0,  6'd0,  4'd0, 2'd0},
    '{1'b0, 19'd0, 1'b0, 1'b1, 1'b1, MODE_STOP, 7'd99, 6'd59, 6'd58, 4'd8, 2'd0},
    '{1'b0, 19'd0, 1'b0, 1'b0, 1'b1, MODE_STOP, 7'd99, 6'd59, 6'd58, 4'd8, 2'd0},
    '{1'b1, 19'd3600, 1'b0, 1'b0, 1'b0, MODE_IDLE, 7'd0, 6'd0, 6'd0, 4'd0, 2'd0},
    '{1'b0, 19'd0, 1'b1, 1'b1, 1'b1, MODE_IDLE, 7'd1, 6'd0,  6'd0,  4'd0, 2'd0},
    '{1'b0, 19'd0, 1'b0, 1'b0, 1'b1, MODE_IDLE, 7'd1, 6'd0,  6'd0,  4'd0, 2'd0},
    '{1'b0, 19'd0, 1'b1, 1'b1, 1'b1, MODE_RUN,  7'd0, 6'd59, 6'd59, 4'd9, 2'd1},
    '{1'b1, 19'd1, 1'b0, 1'b0, 1'b0, MODE_IDLE, 7'd0, 6'd0, 6'd0, 4'd0, 2'd0},
    '{1'b0, 19'd0, 1'b1, 1'b0, 1'b0, MODE_RUN,  7'd0, 6'd0,  6'd0,  4'd0, 2'd0},
    '{1'b0, 19'd0, 1'b0, 1'b1, 1'b1, MODE_STOP, 7'd0, 6'd59, 6'd59, 4'd8, 2'd2},
    '{1'b0, 19'd0, 1'b0, 1'b0, 1'b1, MODE_STOP, 7'd0, 6'd59, 6'd59, 4'd8, 2'd2},
    '{1'b0, 19'd0, 1'b0, 1'b1, 1'b1, MODE_IDLE, 7'd0, 6'd0,  6'd1,  4'd0, 2'd2},
    '{1'b0, 19'd0, 1'b0, 1'b0, 1'b1, MODE_IDLE, 7'd0, 6'd0,  6'd1,  4'd0, 2'd2},
    '{1'b0, 19'd0, 1'b1, 1'b1, 1'b1, MODE_RUN,  7'd0, 6'd0,  6'd0,  4'd9, 2'd3}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [18:0] cfg_data_i = '0;
  logic        cfg_ready_o;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // tick [0], button [1], zero [7:2]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // run_state [1:0], hours_left [8:2],
                                    // minutes_left [14:9], seconds_left [20:15],
                                    // tenths_left [24:21], spinner [26:25], zero

  hms_countdown_timer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .cfg_ready_o   (cfg_ready_o),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [TotalW-1:0] start_cfg = RST_TOTAL;
  logic [ModeW-1:0]  tm_mode = MODE_IDLE;
  logic [TotalW-1:0] tm_total = RST_TOTAL;
  logic [HoursW-1:0] tm_hours = RST_HOURS;
  logic [MinW-1:0]   tm_minutes = RST_MINUTES;
  logic [SecW-1:0]   tm_seconds = RST_SECONDS;
  logic [TenthW-1:0] tm_tenths = '0;
  logic [SpinW-1:0]  tm_spin = '0;
  logic              tm_btn_prev = 1'b0;
  bit                tm_reloaded = 1'b0;

  timer_view_t due_views [$];
  int          mismatches = 0;
  int          steps_sent = 0;
  int          stuck_cycles = 0;
  bit          gaps_on = 1'b1;
  bit          long_hold_req = 1'b0;
  bit          long_hold_done = 1'b0;
  int          hold_cycles = 0;

  function automatic timer_view_t step_timer(input bit tick, input bit button);
    int unsigned secs;
    timer_view_t view;
    if (button && !tm_btn_prev) begin
      case (tm_mode)
        MODE_IDLE: tm_mode = MODE_RUN;
        MODE_RUN:  tm_mode = MODE_STOP;
        default: begin
          tm_mode = MODE_IDLE;
          secs = (start_cfg > MAX_START) ? MAX_START : start_cfg;
          tm_total = TotalW'(secs);
          tm_hours = HoursW'(secs / SEC_PER_HOUR);
          secs = secs % SEC_PER_HOUR;
          tm_minutes = MinW'(secs / SEC_PER_MIN);
          tm_seconds = SecW'(secs % SEC_PER_MIN);
          tm_tenths = '0;
          tm_reloaded = 1'b1;
        end
      endcase
    end
    tm_btn_prev = button;
    if (tm_mode == MODE_RUN && tick && !(tm_total == '0 && tm_tenths == '0)) begin
      if (tm_tenths != '0) begin
        tm_tenths = tm_tenths - 1'b1;
      end else begin
        tm_tenths = LAST_TENTH;
        tm_total = tm_total - 1'b1;
        if (tm_seconds != '0) begin
          tm_seconds = tm_seconds - 1'b1;
        end else begin
          tm_seconds = LAST_SECOND;
          if (tm_minutes != '0) begin
            tm_minutes = tm_minutes - 1'b1;
          end else begin
            tm_minutes = LAST_MINUTE;
            if (tm_hours != '0) tm_hours = tm_hours - 1'b1;
          end
        end
      end
      tm_spin = tm_spin + 1'b1;
    end
    if (tm_total == '0 && tm_tenths == '0) tm_mode = MODE_STOP;
    view.run_state = tm_mode;
    view.hours     = tm_hours;
    view.minutes   = tm_minutes;
    view.seconds   = tm_seconds;
    view.tenths    = tm_tenths;
    view.spinner   = tm_spin;
    return view;
  endfunction

  task automatic send_step(input bit tick, input bit button, input bit typed,
                           input timer_view_t typed_view);
    timer_view_t view;
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, button, tick};
    do @(posedge clk_i); while (!s_axis_tready);
    view = step_timer(tick, button);
    due_views.push_back(typed ? typed_view : view);
    steps_sent++;
  endtask

  task automatic write_start(input logic [TotalW-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (due_views.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    start_cfg = value;
  endtask

  initial begin : stimulus
    int unsigned       burst;
    bit                noise;
    logic [TotalW-1:0] start_pick;
    timer_view_t       typed_view;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (PLAN[i]) begin
      if (PLAN[i].is_cfg) begin
        write_start(PLAN[i].cfg_value);
      end else begin
        typed_view.run_state = PLAN[i].run_state;
        typed_view.hours     = PLAN[i].hours;
        typed_view.minutes   = PLAN[i].minutes;
        typed_view.seconds   = PLAN[i].seconds;
        typed_view.tenths    = PLAN[i].tenths;
        typed_view.spinner   = PLAN[i].spinner;
        send_step(PLAN[i].tick, PLAN[i].button, PLAN[i].typed, typed_view);
      end
    end

    while (steps_sent < PLAN_STEPS + RANDOM_STEPS) begin
      gaps_on <= (steps_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0: start_pick = '0;
          1: start_pick = MAX_START;
          2: start_pick = TotalW'($urandom_range(MAX_START + 1, 19'h7FFFF));
          3: start_pick = TotalW'($urandom_range(3599, 3601));
          4: start_pick = TotalW'($urandom_range(59, 61));
          5: start_pick = TotalW'($urandom);
          default: start_pick = TotalW'($urandom_range(1, 6));
        endcase
        write_start(start_pick);
      end
      if (steps_sent >= 300 && !long_hold_req) long_hold_req <= 1'b1;
      tm_reloaded = 1'b0;
      while (!tm_reloaded) begin
        send_step(1'($urandom_range(0, 1)), 1'b1, 1'b0, '0);
        send_step(1'($urandom_range(0, 1)), 1'b0, 1'b0, '0);
      end
      send_step(1'($urandom_range(0, 1)), 1'b1, 1'b0, '0);
      burst = $urandom_range(20, 100);
      noise = ($urandom_range(0, 4) == 0);
      repeat (burst) begin
        if (noise) begin
          send_step(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
        end else begin
          send_step($urandom_range(0, 3) != 0, $urandom_range(0, 29) == 0, 1'b0, '0);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (due_views.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && due_views.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  always @(posedge clk_i) begin : drain_results
    timer_view_t got;
    timer_view_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = timer_view_t'(m_axis_tdata[ViewW-1:0]);
      if (due_views.size() == 0) begin
        if (mismatches < 10) $display("result beat with nothing due: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = due_views.pop_front();
        if (got != want || m_axis_tdata[31:ViewW] != '0) begin
          if (mismatches < 10) begin
            $write("mismatch: want mode %0d %0d:%0d:%0d.%0d spin %0d, ",
                   want.run_state, want.hours, want.minutes, want.seconds, want.tenths,
                   want.spinner);
            $display("got mode %0d %0d:%0d:%0d.%0d spin %0d pad %0h",
                     got.run_state, got.hours, got.minutes, got.seconds, got.tenths,
                     got.spinner, m_axis_tdata[31:ViewW]);
          end
          mismatches++;
        end
      end
    end
    if (hold_cycles != 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done = 1'b1;
      hold_cycles = LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 11) == 0) begin
      hold_cycles = $urandom_range(0, 12);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule

@@ hms_countdown_timer_unit.f @@
+incdir+rtl/core
rtl/core/hmsct_pkg.sv
rtl/core/hmsct_split.sv
rtl/core/hms_countdown_timer_unit.sv
dv/hms_countdown_timer_unit_test.sv
